// ===== design/opq_pkg.sv =====
// Shared types and constants for the ordered priority queue with aging.
// Used by opq_store, opq_seq and ordered_priority_queue_with_aging.
package opq_pkg;

  // Table geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int AGE_W       = CNT_W + 1;

  // Fixed port field widths
  localparam int PRIO_W      = 2;
  localparam int PORT_ID_W   = 16;
  localparam int COUNT_W     = 5;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 24;

  // Aging covers entries while 3 * (index + 1) <= occupancy
  localparam int AGE_DIV     = 3;
  localparam logic [PRIO_W-1:0] PRIO_FLOOR = 2'd1;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_AGE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  // Memory access request from the sequencer
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  // Accepted command
  typedef struct packed {
    mode_t                mode;
    logic [PRIO_W-1:0]    prio;
    logic [PORT_ID_W-1:0] tid;
  } cmd_t;

  // Finished result
  typedef struct packed {
    logic                 found;
    logic [PORT_ID_W-1:0] id;
    logic [COUNT_W-1:0]   count;
    status_t              status;
  } res_t;

endpackage

// ===== design/opq_store.sv =====
// Entry table: one write port, one registered read port.
// Depends on opq_pkg for the entry and request types.
module opq_store import opq_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem [QUEUE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== design/opq_seq.sv =====
// Command sequencer: walks the entry table for remove, find and age, appends on push.
// Depends on opq_pkg; drives the opq_store request and reads its registered data.
module opq_seq import opq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  cmd_t     cmd,
  output logic     idle,
  output logic     res_valid,
  input  logic     res_take,
  output res_t     res,
  output mem_req_t req,
  input  entry_t   rd_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PUSH  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_SHIFT = 6'b001000,
    S_AGE   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t               state;
  cmd_t                 cur;
  logic [CNT_W-1:0]     occ;
  logic [ID_BITS-1:0]   seq;
  logic [CNT_W-1:0]     ra;
  logic [AGE_W-1:0]     age3;
  logic                 rvalid;
  logic [IDX_W-1:0]     addr_d;
  logic                 res_found;
  logic [PORT_ID_W-1:0] res_id;
  status_t              res_status;

  logic               issue;
  logic               drained;
  logic               id_hit;
  logic               prio_hit;
  logic [ID_BITS-1:0] seq_inc;

  // Read issue and match decode
  always_comb begin
    issue = 1'b0;
    unique case (state) inside
      S_SCAN, S_SHIFT: issue = (ra < occ);
      S_AGE:           issue = (age3 <= AGE_W'(occ));
      default:         issue = 1'b0;
    endcase
    drained  = !issue && !rvalid;
    id_hit   = rvalid && (cur.mode == MODE_REMOVE) && (rd_data.id == ID_BITS'(cur.tid));
    prio_hit = rvalid && (cur.mode == MODE_FIND) && (rd_data.prio == cur.prio);
    seq_inc  = seq + ID_BITS'(1);
  end

  // Memory request
  always_comb begin
    req.rd_en   = issue;
    req.rd_addr = ra[IDX_W-1:0];
    req.wr_en   = 1'b0;
    req.wr_addr = '0;
    req.wr_data = rd_data;
    unique case (state)
      S_PUSH: begin
        req.wr_en        = (occ < CNT_W'(QUEUE_DEPTH));
        req.wr_addr      = occ[IDX_W-1:0];
        req.wr_data.id   = seq_inc;
        req.wr_data.prio = cur.prio;
      end
      S_SHIFT: begin
        // Move entry down one slot to close the gap
        req.wr_en   = rvalid;
        req.wr_addr = addr_d - IDX_W'(1);
      end
      S_AGE: begin
        req.wr_en   = rvalid;
        req.wr_addr = addr_d;
        if (rd_data.prio > PRIO_FLOOR) begin
          req.wr_data.prio = rd_data.prio - PRIO_W'(1);
        end
      end
      default: req.wr_en = 1'b0;
    endcase
  end

  // Sequencer state and table bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      occ    <= '0;
      seq    <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= issue;
      addr_d <= ra[IDX_W-1:0];
      if (issue) begin
        ra   <= ra + CNT_W'(1);
        age3 <= age3 + AGE_W'(AGE_DIV);
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur  <= cmd;
            ra   <= '0;
            age3 <= AGE_W'(AGE_DIV);
            unique case (cmd.mode) inside
              MODE_PUSH:              state <= S_PUSH;
              MODE_REMOVE, MODE_FIND: state <= S_SCAN;
              default:                state <= S_AGE;
            endcase
          end
        end
        S_PUSH: begin
          res_found <= 1'b0;
          if (occ >= CNT_W'(QUEUE_DEPTH)) begin
            res_id     <= '0;
            res_status <= ST_FULL;
          end else begin
            seq        <= seq_inc;
            occ        <= occ + CNT_W'(1);
            res_id     <= PORT_ID_W'(seq_inc);
            res_status <= ST_OK;
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          if (id_hit) begin
            res_found  <= 1'b1;
            res_id     <= PORT_ID_W'(rd_data.id);
            res_status <= ST_OK;
            state      <= S_SHIFT;
          end else if (prio_hit) begin
            res_found  <= 1'b1;
            res_id     <= PORT_ID_W'(rd_data.id);
            res_status <= ST_OK;
            state      <= S_DONE;
          end else if (drained) begin
            res_found  <= 1'b0;
            res_id     <= '0;
            res_status <= ST_MISS;
            state      <= S_DONE;
          end
        end
        S_SHIFT: begin
          if (drained) begin
            occ   <= occ - CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_AGE: begin
          if (drained) begin
            res_found  <= 1'b0;
            res_id     <= '0;
            res_status <= ST_OK;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle       = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign res.found  = res_found;
  assign res.id     = res_id;
  assign res.count  = COUNT_W'(occ);
  assign res.status = res_status;

endmodule

// ===== design/ordered_priority_queue_with_aging.sv =====
// Ordered priority queue with aging: up to QUEUE_DEPTH entries kept oldest first, each
// with an id and a priority. Push appends with the next id, remove deletes an id and closes
// the gap, find returns the oldest entry of a priority, age decrements the priority of the
// first count/3 entries, not below priority 1. One command is worked at a time and gives
// one result transaction. Find and remove walk the table from the oldest entry (remove
// walks the whole table, shifting the tail down one entry per cycle) and age walks its
// first count/3 entries; the walks are paced by the single read port of the entry table,
// which delivers one entry per cycle. A new command is accepted while a result waits on
// the output.
// Depends on opq_pkg, opq_store and opq_seq.
module ordered_priority_queue_with_aging import opq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // mode[1:0], new_priority[3:2], target_id[19:4]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // found[0], result_id[16:1],
                                               // entry_count[21:17], status[23:22]
);

  cmd_t     cmd;
  logic     start;
  logic     idle;
  logic     res_valid;
  logic     res_take;
  res_t     res;
  res_t     out_res;
  mem_req_t req;
  entry_t   rd_data;

  // Input unpacking
  assign cmd.mode      = mode_t'(s_axis_tdata[1:0]);
  assign cmd.prio      = s_axis_tdata[3:2];
  assign cmd.tid       = s_axis_tdata[19:4];
  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid && idle;

  opq_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  opq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .idle      (idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .req       (req),
    .rd_data   (rd_data)
  );

  // Output register, loaded when empty or being drained
  assign res_take = res_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {out_res.status, out_res.count, out_res.id, out_res.found};

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[21:17] <= COUNT_W'(QUEUE_DEPTH)))
    else $error("entry count above table depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[23:22] == ST_FULL))
      |-> (m_axis_tdata[21:17] == COUNT_W'(QUEUE_DEPTH)))
    else $error("full status with table not full");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[23:22] == ST_OK))
    else $error("found flag with non-ok status");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !s_axis_tready)
    else $error("input ready while a result is pending in the sequencer");

endmodule
